FILE: sv/stkmrp_pkg.sv
// shared constants and types of the stack unit
package stkmrp_pkg;

  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 3;
  localparam int STATUS_W  = 3;
  localparam int CODE_W    = 7;
  localparam int DEPTH_W   = 6;
  localparam int DEPTH_DEF = 32;
  localparam int CHAR_MAX  = 127;
  localparam int MIN_OPS   = 2;
  localparam int MAX_CHARS = 32;
  localparam int NCHAR_W   = $clog2(MAX_CHARS + 1);
  localparam int STEP_W    = $clog2(DATA_W);

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_MOD   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PCHAR = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PSTR  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_ROTL  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_ROTR  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVF   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MOD_RDB,
    S_MOD_RDA,
    S_MOD_WAIT,
    S_PCHAR_RD,
    S_PSTR_CHK,
    S_PSTR_RD,
    S_ROT_LOAD,
    S_ROT_RD,
    S_ROT_WR,
    S_RESULT
  } state_t;

  // one pending result transfer
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                char_valid;
    logic [CODE_W-1:0]   char_code;
    logic                line_end;
    logic                last;
  } pend_t;

  // remainder unit handshake
  typedef struct packed {
    logic start;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } rem_rsp_t;

endpackage

FILE: sv/stkmrp_cmd_if.sv
// command channel: operation code and push operand
interface stkmrp_cmd_if import stkmrp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

FILE: sv/stkmrp_res_if.sv
// result channel: status, printed character and stack depth
interface stkmrp_res_if import stkmrp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                char_valid;
  logic [CODE_W-1:0]   char_code;
  logic                line_end;
  logic                last;
  logic [DEPTH_W-1:0]  depth_now;

  modport source (output valid, output status, output char_valid, output char_code,
                  output line_end, output last, output depth_now, input ready);
  modport sink (input valid, input status, input char_valid, input char_code,
                input line_end, input last, input depth_now, output ready);
endinterface

FILE: sv/stkmrp_rem.sv
// iterative signed remainder, one quotient bit per cycle
module stkmrp_rem import stkmrp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rem_req_t          req,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output rem_rsp_t          rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W-1:0] rmd;
  logic              neg;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  assign trial = {rmd, dvd[DATA_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitudes in, sign of the dividend restored at the end
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      rmd <= '0;
      neg <= dividend[DATA_W-1];
    end else if (busy) begin
      dvd <= {dvd[DATA_W-2:0], 1'b0};
      rmd <= diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
    end
  end

  assign rsp.done  = done;
  assign rsp.value = neg ? (~rmd + 1'b1) : rmd;

endmodule

FILE: sv/stack_unit_mod_rotate_print_top.sv
// stack machine execution stack with mod, character print and rotate
//
//  channel  dir  fields                                             transfer
//  cmd      in   func, push_value                                   valid & ready
//  res      out  status, char_valid, char_code, line_end, last,     valid & ready
//                depth_now
//
// mod waits on the remainder unit, one bit a cycle; pstr gives its characters one
// result at a time, then the line end at the bottom or cap, when a value stops the
// walk, or on an empty stack; a rotate of n entries does one read then one write
// per entry through the memory.
// reset clears the entry count, the sequencer and the result valid; stack
// memory contents are not cleared, only live entries are ever used.
// cmd.ready is high only while idle, from the cycle after the last result loads;
// a result waiting in the output register holds the sequencer in its result state.
module stack_unit_mod_rotate_print_top import stkmrp_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  stkmrp_cmd_if.sink   cmd,
  stkmrp_res_if.source res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  // latched command
  logic [FUNC_W-1:0] op;
  logic [DATA_W-1:0] pv;

  // stack bookkeeping
  logic [CW-1:0]      cnt, cnt_next;
  logic [CW-1:0]      idx, idx_next;
  logic [NCHAR_W-1:0] nchar, nchar_next;
  logic [DATA_W-1:0]  tmp, tmp_next;
  logic [DATA_W-1:0]  bval, bval_next;
  pend_t              pend, pend_next;

  // stack memory
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  rem_req_t rem_req;
  rem_rsp_t rem_rsp;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] idx_src;
  logic          rot_end;
  logic          few;
  logic          full;
  logic          rd_wide;

  function automatic pend_t mk_pend(logic [STATUS_W-1:0] st, logic cv,
                                    logic [CODE_W-1:0] code, logic le, logic lst);
    pend_t p;
    p.status     = st;
    p.char_valid = cv;
    p.char_code  = code;
    p.line_end   = le;
    p.last       = lst;
    return p;
  endfunction

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !res.valid || res.ready;
  assign out_load  = (state == S_RESULT) && out_free;

  assign cnt_m1  = cnt - 1'b1;
  assign cnt_m2  = cnt - CW'(MIN_OPS);
  assign few     = cnt < CW'(MIN_OPS);
  assign full    = cnt == CW'(DEPTH);
  // rotl walks down toward the bottom, rotr walks up toward the top
  assign idx_src = (op == FN_ROTL) ? (idx - 1'b1) : (idx + 1'b1);
  assign rot_end = (op == FN_ROTL) ? (idx == '0) : (idx == cnt_m1);
  // value outside the character range
  assign rd_wide = rdata > DATA_W'(CHAR_MAX);

  stkmrp_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .req      (rem_req),
    .dividend (rdata),
    .divisor  (bval),
    .rsp      (rem_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_START;
      end
      S_START: begin
        case (op)
          FN_MOD:   state_next = few ? S_RESULT : S_MOD_RDB;
          FN_PCHAR: state_next = (cnt == '0) ? S_RESULT : S_PCHAR_RD;
          FN_PSTR:  state_next = S_PSTR_CHK;
          FN_ROTL,
          FN_ROTR:  state_next = few ? S_RESULT : S_ROT_LOAD;
          default:  state_next = S_RESULT;
        endcase
      end
      S_MOD_RDB: state_next = S_MOD_RDA;
      S_MOD_RDA: state_next = (bval == '0) ? S_RESULT : S_MOD_WAIT;
      S_MOD_WAIT: begin
        if (rem_rsp.done) state_next = S_RESULT;
      end
      S_PCHAR_RD: state_next = S_RESULT;
      S_PSTR_CHK: begin
        state_next = (idx == '0 || nchar == NCHAR_W'(MAX_CHARS)) ? S_RESULT : S_PSTR_RD;
      end
      S_PSTR_RD:  state_next = S_RESULT;
      S_ROT_LOAD: state_next = S_ROT_RD;
      S_ROT_RD:   state_next = rot_end ? S_RESULT : S_ROT_WR;
      S_ROT_WR:   state_next = S_ROT_RD;
      S_RESULT: begin
        if (out_free) state_next = pend.last ? S_IDLE : S_PSTR_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls and next values
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = pv;
    mem_raddr     = '0;
    rem_req.start = 1'b0;
    cnt_next      = cnt;
    idx_next      = idx;
    nchar_next    = nchar;
    tmp_next      = tmp;
    bval_next     = bval;
    pend_next     = pend;
    case (state)
      S_START: begin
        pend_next = mk_pend(ST_OK, 1'b0, '0, 1'b0, 1'b1);
        case (op)
          FN_PUSH: begin
            if (full) begin
              pend_next.status = ST_OVF;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt[AW-1:0];
              cnt_next  = cnt + 1'b1;
            end
          end
          FN_MOD: begin
            if (few) pend_next.status = ST_SHORT;
            mem_raddr = cnt_m1[AW-1:0];
          end
          FN_PCHAR: begin
            if (cnt == '0) pend_next.status = ST_EMPTY;
            mem_raddr = cnt_m1[AW-1:0];
          end
          FN_PSTR: begin
            idx_next   = cnt;
            nchar_next = '0;
          end
          FN_ROTL: begin
            mem_raddr = cnt_m1[AW-1:0];
            idx_next  = cnt_m1;
          end
          FN_ROTR: begin
            mem_raddr = '0;
            idx_next  = '0;
          end
          default: ;
        endcase
      end
      S_MOD_RDB: begin
        bval_next = rdata;
        mem_raddr = cnt_m2[AW-1:0];
      end
      S_MOD_RDA: begin
        if (bval == '0) pend_next.status = ST_DIV0;
        else rem_req.start = 1'b1;
      end
      S_MOD_WAIT: begin
        if (rem_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m2[AW-1:0];
          mem_wdata = rem_rsp.value;
          cnt_next  = cnt_m1;
        end
      end
      S_PCHAR_RD: begin
        if (rd_wide) pend_next.status = ST_RANGE;
        else pend_next = mk_pend(ST_OK, 1'b1, rdata[CODE_W-1:0], 1'b0, 1'b1);
      end
      S_PSTR_CHK: begin
        pend_next = mk_pend(ST_OK, 1'b0, '0, 1'b1, 1'b1);
        mem_raddr = AW'(idx - 1'b1);
      end
      S_PSTR_RD: begin
        // stop on a zero or a value that is no character
        if (rdata != '0 && !rd_wide) begin
          pend_next  = mk_pend(ST_OK, 1'b1, rdata[CODE_W-1:0], 1'b0, 1'b0);
          idx_next   = idx - 1'b1;
          nchar_next = nchar + 1'b1;
        end
      end
      S_ROT_LOAD: begin
        tmp_next = rdata;
      end
      S_ROT_RD: begin
        if (rot_end) begin
          mem_we    = 1'b1;
          mem_waddr = idx[AW-1:0];
          mem_wdata = tmp;
        end else begin
          mem_raddr = idx_src[AW-1:0];
        end
      end
      S_ROT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0];
        mem_wdata = rdata;
        idx_next  = idx_src;
      end
      default: ;
    endcase
  end

  // memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= cmd.func;
      pv <= cmd.push_value;
    end
    idx <= idx_next;
    if (rst) nchar <= '0;
    else nchar <= nchar_next;
    tmp   <= tmp_next;
    bval  <= bval_next;
    pend  <= pend_next;
    if (out_load) begin
      res.status     <= pend.status;
      res.char_valid <= pend.char_valid;
      res.char_code  <= pend.char_code;
      res.line_end   <= pend.line_end;
      res.last       <= pend.last;
      res.depth_now  <= DEPTH_W'(cnt);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above stack depth");

  a_wr_live: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(mem_waddr) <= cnt))
    else $error("memory write above the stack top");

  a_rem_done: assert property (@(posedge clk) disable iff (rst)
    rem_rsp.done |-> (state == S_MOD_WAIT))
    else $error("remainder finished outside mod wait");

  a_mod_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD_WAIT) |-> !few)
    else $error("mod running with fewer than two entries");

  a_pstr_cap: assert property (@(posedge clk) disable iff (rst)
    nchar <= NCHAR_W'(MAX_CHARS))
    else $error("pstr character count above cap");
`endif

endmodule

FILE: test/tb_stack_unit_mod_rotate_print_top.sv
// testbench of the stack unit: directed corners, back-pressure fill and random traffic
`timescale 1ns / 1ps

module tb_stack_unit_mod_rotate_print_top;
  import stkmrp_pkg::*;

  // func codes the block must ignore (outside the defined operations)
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  // hard stop, far above the slowest legal run (~200 ops, up to 33 results each)
  localparam int CYCLE_LIMIT = 1_000_000;
  // quiet cycles after the last due result, above the longest pstr walk
  localparam int TAIL_CYCLES = 150;
  localparam int RANDOM_OPS  = 72;

  // one result transfer as the block should present it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                char_valid;
    logic [CODE_W-1:0]   char_code;
    logic                line_end;
    logic                last;
    logic [DEPTH_W-1:0]  depth_now;
  } res_item_t;

  logic clk = 1'b0;
  logic rst;

  stkmrp_cmd_if cmd_if ();
  stkmrp_res_if res_if ();

  stack_unit_mod_rotate_print_top i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the stack, index 0 is the bottom
  logic signed [DATA_W-1:0] shadow_stack [DEPTH_DEF];
  int                       shadow_depth;

  // results still owed by the block, oldest first
  res_item_t due_results [$];

  // traffic shaping, percent of cycles
  int send_idle_pct;
  int recv_stall_pct;
  int rx_hold_cycles;

  // run statistics
  int       ops_sent;
  int       results_checked;
  int       mismatch_cnt;
  int       longest_string;
  int       cycle_cnt;
  logic [7:0] status_seen;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic res_item_t make_result(logic [STATUS_W-1:0] st, logic cv,
                                            logic [CODE_W-1:0] code, logic le,
                                            logic lst);
    res_item_t r;
    r.status     = st;
    r.char_valid = cv;
    r.char_code  = code;
    r.line_end   = le;
    r.last       = lst;
    r.depth_now  = DEPTH_W'(shadow_depth);
    return r;
  endfunction

  // applies one operation to the shadow stack and queues the results it owes
  function automatic void stack_apply(logic [FUNC_W-1:0] fn, logic signed [DATA_W-1:0] val);
    logic [STATUS_W-1:0]      st;
    longint                   dividend;
    longint                   divisor;
    logic signed [DATA_W-1:0] moved;
    int                       idx;
    int                       nchars;

    st = ST_OK;
    case (fn)
      FN_PUSH: begin
        if (shadow_depth >= DEPTH_DEF) begin
          st = ST_OVF;
        end else begin
          shadow_stack[shadow_depth] = val;
          shadow_depth++;
        end
      end
      FN_MOD: begin
        if (shadow_depth < MIN_OPS) begin
          st = ST_SHORT;
        end else begin
          divisor  = shadow_stack[shadow_depth-1];
          dividend = shadow_stack[shadow_depth-2];
          // 64-bit math keeps most negative % -1 well defined (gives 0)
          if (divisor == 0) begin
            st = ST_DIV0;
          end else begin
            shadow_stack[shadow_depth-2] = DATA_W'(dividend % divisor);
            shadow_depth--;
          end
        end
      end
      FN_PCHAR: begin
        if (shadow_depth == 0) begin
          st = ST_EMPTY;
        end else if (shadow_stack[shadow_depth-1] < 0 ||
                     shadow_stack[shadow_depth-1] > CHAR_MAX) begin
          st = ST_RANGE;
        end else begin
          due_results.push_back(make_result(ST_OK, 1'b1,
                                            shadow_stack[shadow_depth-1][CODE_W-1:0],
                                            1'b0, 1'b1));
          status_seen[ST_OK] = 1'b1;
          return;
        end
      end
      FN_PSTR: begin
        // walk down until zero, non-printable, bottom or the character cap
        nchars = 0;
        idx    = shadow_depth;
        while (idx > 0 && nchars < MAX_CHARS &&
               shadow_stack[idx-1] > 0 && shadow_stack[idx-1] <= CHAR_MAX) begin
          due_results.push_back(make_result(ST_OK, 1'b1,
                                            shadow_stack[idx-1][CODE_W-1:0],
                                            1'b0, 1'b0));
          nchars++;
          idx--;
        end
        due_results.push_back(make_result(ST_OK, 1'b0, '0, 1'b1, 1'b1));
        if (nchars > longest_string) longest_string = nchars;
        status_seen[ST_OK] = 1'b1;
        return;
      end
      FN_ROTL: begin
        if (shadow_depth >= MIN_OPS) begin
          moved = shadow_stack[shadow_depth-1];
          for (idx = shadow_depth - 1; idx > 0; idx--) shadow_stack[idx] = shadow_stack[idx-1];
          shadow_stack[0] = moved;
        end
      end
      FN_ROTR: begin
        if (shadow_depth >= MIN_OPS) begin
          moved = shadow_stack[0];
          for (idx = 0; idx < shadow_depth - 1; idx++) shadow_stack[idx] = shadow_stack[idx+1];
          shadow_stack[shadow_depth-1] = moved;
        end
      end
      default: ;  // spare codes leave the stack alone
    endcase
    due_results.push_back(make_result(st, 1'b0, '0, 1'b0, 1'b1));
    status_seen[st] = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // offers one operation; valid is left high so the next call can follow back to back
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid      = 1'b1;
    cmd_if.func       = fn;
    cmd_if.push_value = val;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    stack_apply(fn, val);
    ops_sent++;
  endtask

  // drops valid and waits until every owed result has been seen
  task automatic wait_results_done();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // shrinks the stack with mod; a zero on top is rotated away first
  task automatic drain_stack(input int target);
    int guard;
    guard = 0;
    while (shadow_depth > target && shadow_depth >= MIN_OPS && guard < 3 * DEPTH_DEF) begin
      if (shadow_stack[shadow_depth-1] != 0) send_op(FN_MOD, $urandom);
      else send_op(FN_ROTL, $urandom);
      guard++;
    end
  endtask

  // operand mix: mostly printable, plus zero, just out of range, negatives and extremes
  function automatic logic signed [DATA_W-1:0] any_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = $urandom_range(1, CHAR_MAX);
      4:          v = '0;
      5:          v = $urandom_range(CHAR_MAX + 1, 1000);
      6:          v = 32'h0 - $urandom_range(1, 300);
      7: begin
        case ($urandom_range(3))
          0:       v = INT_MIN;
          1:       v = INT_MAX;
          2:       v = -1;
          default: v = 1;
        endcase
      end
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // uniform pick among the six defined operations
  function automatic logic [FUNC_W-1:0] FN_FROM_RANGE();
    case ($urandom_range(5))
      0:       return FN_PUSH;
      1:       return FN_MOD;
      2:       return FN_PCHAR;
      3:       return FN_PSTR;
      4:       return FN_ROTL;
      default: return FN_ROTR;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver: a pending hold-off wins, otherwise random stalls
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      res_if.ready = 1'b0;
      rx_hold_cycles--;
    end else begin
      res_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every result transfer is matched against the oldest owed result
  always @(posedge clk) begin : result_check
    res_item_t seen;
    res_item_t want;
    if (rst === 1'b0 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      seen.status     = res_if.status;
      seen.char_valid = res_if.char_valid;
      seen.char_code  = res_if.char_code;
      seen.line_end   = res_if.line_end;
      seen.last       = res_if.last;
      seen.depth_now  = res_if.depth_now;
      results_checked++;
      if (due_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 20)
          $display("%0t: result transfer with nothing due: status=%0d char_valid=%0b",
                   $time, seen.status, seen.char_valid,
                   " char_code=%0d line_end=%0b last=%0b depth_now=%0d",
                   seen.char_code, seen.line_end, seen.last, seen.depth_now);
      end else begin
        want = due_results.pop_front();
        if (seen !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 20)
            $display("%0t: result mismatch, expected status=%0d cv=%0b code=%0d le=%0b",
                     $time, want.status, want.char_valid, want.char_code, want.line_end,
                     " last=%0b depth=%0d, actual status=%0d cv=%0b code=%0d le=%0b",
                     want.last, want.depth_now, seen.status, seen.char_valid,
                     seen.char_code, seen.line_end,
                     " last=%0b depth=%0d", seen.last, seen.depth_now);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: no progress within %0d cycles, %0d results still due",
               $time, CYCLE_LIMIT, due_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // faults and no-ops on an empty and a one-entry stack, spare codes
  task automatic test_empty_stack();
    send_op(FN_PCHAR, $urandom);   // empty
    send_op(FN_PSTR, $urandom);    // line end only
    send_op(FN_MOD, $urandom);     // too short
    send_op(FN_ROTL, $urandom);
    send_op(FN_ROTR, $urandom);
    send_op(FN_SPARE6, $urandom);  // ignored
    send_op(FN_SPARE7, $urandom);
    send_op(FN_PUSH, 65);
    send_op(FN_MOD, $urandom);     // one entry still too short
    send_op(FN_ROTL, $urandom);    // single entry rotates to itself
    send_op(FN_ROTR, $urandom);
    send_op(FN_PCHAR, $urandom);
    wait_results_done();
  endtask

  // receiver holds off so the pushes back up behind it, then a full-depth string
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_cycles = 300;
    while (shadow_depth < DEPTH_DEF) send_op(FN_PUSH, $urandom_range(1, CHAR_MAX));
    send_op(FN_PUSH, INT_MAX);     // overflow, stack untouched
    send_op(FN_PSTR, $urandom);    // hits both the bottom and the character cap
    send_op(FN_ROTL, $urandom);
    send_op(FN_PCHAR, $urandom);
    send_op(FN_ROTR, $urandom);
    send_op(FN_PSTR, $urandom);
    wait_results_done();
  endtask

  // remainder signs, divide by zero and most negative by minus one
  task automatic test_mod_corners();
    drain_stack(24);
    send_op(FN_PUSH, INT_MIN);
    send_op(FN_PUSH, -1);
    send_op(FN_MOD, $urandom);     // gives 0
    send_op(FN_PUSH, 9);
    send_op(FN_PUSH, 0);
    send_op(FN_MOD, $urandom);     // divide by zero, no change
    send_op(FN_ROTL, $urandom);    // zero to the bottom
    send_op(FN_PUSH, -7);
    send_op(FN_PUSH, 2);
    send_op(FN_MOD, $urandom);     // -1, sign of the dividend
    send_op(FN_PUSH, 7);
    send_op(FN_PUSH, -2);
    send_op(FN_MOD, $urandom);     // 1
    send_op(FN_PUSH, INT_MAX);
    send_op(FN_PUSH, INT_MIN);
    send_op(FN_MOD, $urandom);     // dividend unchanged
    wait_results_done();
  endtask

  // character range limits and the ways a string walk stops
  task automatic test_print_corners();
    drain_stack(22);
    send_op(FN_PUSH, CHAR_MAX + 1);
    send_op(FN_PCHAR, $urandom);   // out of range
    send_op(FN_PUSH, -1);
    send_op(FN_PCHAR, $urandom);   // negative is out of range too
    send_op(FN_PSTR, $urandom);    // stops right away at a negative
    send_op(FN_PUSH, 0);
    send_op(FN_PCHAR, $urandom);   // zero is a legal character
    send_op(FN_PSTR, $urandom);    // stops right away at zero
    send_op(FN_PUSH, CHAR_MAX);
    send_op(FN_PUSH, 1);
    send_op(FN_PSTR, $urandom);    // two characters then the terminator
    wait_results_done();
  endtask

  // random traffic: mostly strings and mod pairs with random content, some noise
  task automatic test_random_traffic();
    int send_pct [4];
    int recv_pct [4];
    int phase;
    int start_ops;
    int len;
    int k;
    logic signed [DATA_W-1:0] v;
    send_pct = '{0, 85, 0, 12};
    recv_pct = '{0, 0, 85, 12};
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      start_ops      = ops_sent;
      while (ops_sent - start_ops < RANDOM_OPS / 4) begin
        case ($urandom_range(9))
          0, 1, 2: begin
            // a string: optional terminator, characters, then the print
            len = ($urandom_range(5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            if (shadow_depth + len + 1 > DEPTH_DEF)
              drain_stack(DEPTH_DEF - len - 1 - $urandom_range(0, 6));
            if ($urandom_range(1)) send_op(FN_PUSH, '0);
            for (k = 0; k < len; k++) begin
              v = ($urandom_range(7) == 0) ? any_value() : $urandom_range(1, CHAR_MAX);
              send_op(FN_PUSH, v);
            end
            send_op(FN_PSTR, $urandom);
          end
          3, 4: begin
            if (shadow_depth > DEPTH_DEF - 2) drain_stack(DEPTH_DEF - 2 - $urandom_range(0, 8));
            send_op(FN_PUSH, any_value());
            send_op(FN_PUSH, ($urandom_range(9) == 0) ? '0 : any_value());
            send_op(FN_MOD, $urandom);
          end
          5: begin
            send_op($urandom_range(1) ? FN_ROTL : FN_ROTR, $urandom);
            send_op($urandom_range(1) ? FN_PCHAR : FN_PSTR, $urandom);
          end
          default: begin
            send_op(FN_FROM_RANGE(), any_value());
          end
        endcase
      end
    end
    wait_results_done();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst               = 1'b1;
    cmd_if.valid      = 1'b0;
    cmd_if.func       = FN_PUSH;
    cmd_if.push_value = '0;
    res_if.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rx_hold_cycles    = 0;
    shadow_depth      = 0;
    ops_sent          = 0;
    results_checked   = 0;
    mismatch_cnt      = 0;
    longest_string    = 0;
    cycle_cnt         = 0;
    status_seen       = '0;
    for (int i = 0; i < DEPTH_DEF; i++) shadow_stack[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_stack();
    test_backpressure_fill();
    test_mod_corners();
    test_print_corners();
    test_random_traffic();

    // let any stray result show up before judging
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d operations, checked %0d result transfers, longest string %0d chars",
             ops_sent, results_checked, longest_string);
    $display("status codes reached (bit per code): %b, %0d mismatches",
             status_seen[5:0], mismatch_cnt);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
